@@ src/cfcrc_pkg.sv @@
// Package for the configurable CRC-16 engine: widths, register indexes,
// the configuration struct and the polynomial bit-reversal function.
// No dependencies.
package cfcrc_pkg;

  localparam int unsigned CrcW   = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegPolynomial   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegInitialValue = 8'd1;
  localparam logic [CfgIdxW-1:0] RegReflected    = 8'd2;
  localparam logic [CfgIdxW-1:0] RegSwapBytes    = 8'd3;

  // Reset values of the registers.
  localparam logic [CrcW-1:0] PolyReset = 16'h1021;
  localparam logic [CrcW-1:0] InitReset = 16'hFFFF;

  typedef struct packed {
    logic [CrcW-1:0] polynomial;
    logic [CrcW-1:0] initial_value;
    logic            reflected_mode;
    logic            swap_result_bytes;
  } cfg_t;

  function automatic logic [CrcW-1:0] reverse16(input logic [CrcW-1:0] v);
    logic [CrcW-1:0] r;
    for (int i = 0; i < CrcW; i++) begin
      r[CrcW-1-i] = v[i];
    end
    return r;
  endfunction

endpackage

@@ src/cfcrc_cfg.sv @@
// Configuration register bank of the CRC-16 engine.
// Depends on cfcrc_pkg.
module cfcrc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfcrc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [cfcrc_pkg::CrcW-1:0]    cfg_data_i,
  output cfcrc_pkg::cfg_t               cfg_o,
  output logic                          init_load_o
);
  import cfcrc_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic init_load;

  always_comb begin
    cfg_d     = cfg_q;
    init_load = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegPolynomial:   cfg_d.polynomial = cfg_data_i;
        RegInitialValue: begin
          cfg_d.initial_value = cfg_data_i;
          init_load           = 1'b1;
        end
        RegReflected:    cfg_d.reflected_mode    = cfg_data_i[0];
        RegSwapBytes:    cfg_d.swap_result_bytes = cfg_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.polynomial        <= PolyReset;
      cfg_q.initial_value     <= InitReset;
      cfg_q.reflected_mode    <= 1'b0;
      cfg_q.swap_result_bytes <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o       = cfg_q;
  assign init_load_o = init_load;

endmodule

@@ src/cfcrc_fold.sv @@
// Byte fold of the CRC-16: eight unrolled bit steps, MSB-first or
// LSB-first with the reversed polynomial. Depends on cfcrc_pkg.
module cfcrc_fold (
  input  logic [cfcrc_pkg::CrcW-1:0]  crc_i,
  input  logic [cfcrc_pkg::ByteW-1:0] data_i,
  input  logic [cfcrc_pkg::CrcW-1:0]  polynomial_i,
  input  logic                        reflected_i,
  output logic [cfcrc_pkg::CrcW-1:0]  crc_o
);
  import cfcrc_pkg::*;

  logic [CrcW-1:0] rev_poly;
  logic [CrcW-1:0] c;

  assign rev_poly = reverse16(polynomial_i);

  always_comb begin
    if (reflected_i) begin
      c = crc_i ^ {{(CrcW-ByteW){1'b0}}, data_i};
      for (int i = 0; i < ByteW; i++) begin
        c = c[0] ? ((c >> 1) ^ rev_poly) : (c >> 1);
      end
    end else begin
      c = crc_i ^ {data_i, {(CrcW-ByteW){1'b0}}};
      for (int i = 0; i < ByteW; i++) begin
        c = c[CrcW-1] ? ((c << 1) ^ polynomial_i) : (c << 1);
      end
    end
  end

  assign crc_o = c;

endmodule

@@ src/configurable_crc16_engine.sv @@
// Configurable CRC-16 engine: an accepted last beat passes the input register,
// then the result register, before the result beat. One byte per cycle is
// taken unless a last beat waits on a stalled result; the eight bit steps are
// one XOR network between the input register and the running CRC register.
// Reset clears both stages and loads the defaults (polynomial 0x1021,
// initial value 0xFFFF, normal bit order, no byte swap).
module configurable_crc16_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cfcrc_pkg::ByteW-1:0]   data_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cfcrc_pkg::CrcW-1:0]    crc_value_o,
  input  logic                          cfg_we_i,
  input  logic [cfcrc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [cfcrc_pkg::CrcW-1:0]    cfg_data_i
);
  import cfcrc_pkg::*;

  cfg_t             cfg;
  logic             init_load;

  logic             in_valid_q;
  logic [ByteW-1:0] data_q;
  logic             last_q;
  logic [CrcW-1:0]  crc_q, crc_d;
  logic [CrcW-1:0]  fold_crc;
  logic             out_valid_q;
  logic [CrcW-1:0]  out_crc_q;
  logic             out_free;
  logic             advance;
  logic             in_accept;

  cfcrc_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o       (cfg),
    .init_load_o (init_load)
  );

  cfcrc_fold u_fold (
    .crc_i        (crc_q),
    .data_i       (data_q),
    .polynomial_i (cfg.polynomial),
    .reflected_i  (cfg.reflected_mode),
    .crc_o        (fold_crc)
  );

  // A non-last beat never needs the result register, so it always moves on.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!last_q || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    crc_d = crc_q;
    if (init_load) begin
      crc_d = cfg_data_i;
    end else if (advance) begin
      crc_d = last_q ? cfg.initial_value : fold_crc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      crc_q       <= InitReset;
    end else begin
      crc_q <= crc_d;
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && last_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (advance && last_q) begin
      out_crc_q <= cfg.swap_result_bytes ? {fold_crc[ByteW-1:0], fold_crc[CrcW-1:ByteW]}
                                         : fold_crc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = out_crc_q;

  // An accepted beat is always held in the input register on the next cycle.
  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_valid_q)
    else $error("accepted beat did not reach the input register");

  // A last beat that moves on always produces a result beat.
  a_last_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && last_q) |=> out_valid_q)
    else $error("last beat did not produce a result");

  // After a message ends the running CRC restarts from the initial value.
  a_crc_reload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && last_q) |=> (crc_q == cfg.initial_value))
    else $error("CRC register not reloaded after last beat");

  // A last beat must wait while a result is still held back.
  a_last_waits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && last_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("last beat moved on over a stalled result");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for configurable_crc16_engine: drives message bytes and
// register writes, predicts each finished CRC and checks every result beat.
// Depends on cfcrc_pkg and the engine RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfcrc_pkg::*;

  // Indexes outside the register map; writes to them must leave everything alone.
  localparam logic [CfgIdxW-1:0] IdxUnmappedLow = 8'd4;
  localparam logic [CfgIdxW-1:0] IdxUnmappedTop = 8'd255;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned ItemsPerPhase = 190;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [ByteW-1:0]   data_byte_i = '0;
  logic               last_byte_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [CrcW-1:0]    crc_value_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CrcW-1:0]    cfg_data_i = '0;

  // Predicted engine state.
  logic [CrcW-1:0] crc_poly = PolyReset;
  logic [CrcW-1:0] crc_init = InitReset;
  logic            crc_reflect = 1'b0;
  logic            crc_swap = 1'b0;
  logic [CrcW-1:0] crc_running = InitReset;

  logic [CrcW-1:0] pending_crcs[$];
  int unsigned     error_count = 0;
  int unsigned     gap_pct = 0;
  int unsigned     stall_pct = 0;

  configurable_crc16_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .crc_value_o (crc_value_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [CrcW-1:0] crc_after_byte(input logic [CrcW-1:0] crc,
                                                     input logic [ByteW-1:0] b);
    logic [CrcW-1:0] r;
    logic [CrcW-1:0] rev_poly;
    r = crc;
    for (int k = 0; k < CrcW; k++) rev_poly[k] = crc_poly[CrcW-1-k];
    if (crc_reflect) begin
      r = r ^ {8'h00, b};
      for (int k = 0; k < ByteW; k++) r = r[0] ? ((r >> 1) ^ rev_poly) : (r >> 1);
    end else begin
      r = r ^ {b, 8'h00};
      for (int k = 0; k < ByteW; k++) r = r[CrcW-1] ? ((r << 1) ^ crc_poly) : (r << 1);
    end
    return r;
  endfunction

  function automatic void note_error(input string what, input logic [CrcW-1:0] expected,
                                     input logic [CrcW-1:0] actual);
    error_count++;
    if (error_count <= ReportLimit) begin
      $display("%0t ns: %s: expected %h, got %h", $realtime, what, expected, actual);
    end
  endfunction

  // Result side: random stall and comparison with the oldest predicted CRC.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_crcs.size() == 0) begin
        note_error("result beat with no CRC pending", '0, crc_value_o);
      end else if (crc_value_o !== pending_crcs[0]) begin
        note_error("crc_value mismatch", pending_crcs[0], crc_value_o);
        void'(pending_crcs.pop_front());
      end else begin
        void'(pending_crcs.pop_front());
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Presents one byte, holds it until accepted and updates the prediction.
  task automatic send_beat(input logic [ByteW-1:0] data, input logic last);
    logic [CrcW-1:0] folded;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    folded = crc_after_byte(crc_running, data);
    if (last) begin
      pending_crcs.push_back(crc_swap ? {folded[7:0], folded[15:8]} : folded);
      crc_running = crc_init;
    end else begin
      crc_running = folded;
    end
  endtask

  // Waits until every pending CRC has come out and the pipeline has emptied,
  // so that a register write cannot overtake a beat still in flight.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_crcs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CrcW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      RegPolynomial: crc_poly = data;
      RegInitialValue: begin
        crc_init    = data;
        crc_running = data;
      end
      RegReflected: crc_reflect = data[0];
      RegSwapBytes: crc_swap = data[0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_variant(input logic [CrcW-1:0] poly, input logic [CrcW-1:0] init,
                             input logic reflect, input logic swap);
    write_reg(RegPolynomial, poly);
    write_reg(RegInitialValue, init);
    write_reg(RegReflected, {15'h0000, reflect});
    write_reg(RegSwapBytes, {15'h0000, swap});
  endtask

  // Reset settings (CCITT-FALSE) with the extreme byte values.
  task automatic test_reset_defaults();
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h80, 1'b0);
    send_beat(8'h01, 1'b1);
    settle_idle();
  endtask

  // Upper data bits are dropped and unmapped indexes are ignored.
  task automatic test_register_masking();
    write_reg(RegReflected, 16'hFFFE);
    write_reg(RegSwapBytes, 16'hFFFF);
    write_reg(IdxUnmappedLow, 16'h0000);
    write_reg(IdxUnmappedTop, 16'hA5A5);
    send_beat(8'h5A, 1'b1);
    settle_idle();
    write_reg(RegReflected, 16'hFF01);
    write_reg(RegSwapBytes, 16'h00FE);
    send_beat(8'hC3, 1'b1);
    settle_idle();
  endtask

  // XMODEM, Kermit, MODBUS and a byte-swapped MODBUS.
  task automatic test_standard_variants();
    set_variant(16'h1021, 16'h0000, 1'b0, 1'b0);
    send_beat(8'h31, 1'b0);
    send_beat(8'h32, 1'b1);
    settle_idle();
    set_variant(16'h1021, 16'h0000, 1'b1, 1'b0);
    send_beat(8'h31, 1'b0);
    send_beat(8'h32, 1'b1);
    settle_idle();
    set_variant(16'h8005, 16'hFFFF, 1'b1, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'h03, 1'b1);
    settle_idle();
    set_variant(16'h8005, 16'hFFFF, 1'b1, 1'b1);
    send_beat(8'hFE, 1'b0);
    send_beat(8'h7F, 1'b1);
    settle_idle();
  endtask

  task automatic test_polynomial_extremes();
    set_variant(16'h0000, 16'hFFFF, 1'b0, 1'b0);
    send_beat(8'hA5, 1'b1);
    settle_idle();
    set_variant(16'hFFFF, 16'h0000, 1'b1, 1'b1);
    send_beat(8'h5A, 1'b1);
    settle_idle();
  endtask

  // Settings changed part-way through a message act from the next byte on,
  // and a new initial value abandons the message altogether.
  task automatic test_mid_message_writes();
    set_variant(16'h1021, 16'h1D0F, 1'b0, 1'b0);
    send_beat(8'h12, 1'b0);
    send_beat(8'h34, 1'b0);
    settle_idle();
    write_reg(RegPolynomial, 16'h8005);
    send_beat(8'h56, 1'b0);
    settle_idle();
    write_reg(RegReflected, 16'h0001);
    send_beat(8'h78, 1'b1);
    settle_idle();
    send_beat(8'h9A, 1'b0);
    settle_idle();
    write_reg(RegInitialValue, 16'h0F0F);
    send_beat(8'hBC, 1'b1);
    settle_idle();
  endtask

  // Random messages under each idling pattern, with random settings and the
  // odd register write in the middle of a message.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned msg_len;
    int unsigned idle_gap[4];
    int unsigned idle_stall[4];
    logic [CfgIdxW-1:0] idx;
    idle_gap   = '{0, 64, 0, 11};
    idle_stall = '{0, 0, 64, 11};
    for (int phase = 0; phase < 4; phase++) begin
      gap_pct   = idle_gap[phase];
      stall_pct = idle_stall[phase];
      set_variant(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
      sent = 0;
      while (sent < ItemsPerPhase) begin
        msg_len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        for (int i = 0; i < msg_len; i++) begin
          send_beat(8'($urandom), i == msg_len - 1);
          sent++;
          if (i != msg_len - 1 && $urandom_range(19) == 0) begin
            settle_idle();
            idx = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3));
            write_reg(idx, 16'($urandom));
          end
        end
      end
      settle_idle();
    end
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_masking();
    test_standard_variants();
    test_polynomial_extremes();
    test_mid_message_writes();
    test_random_traffic();
    settle_idle();
    repeat (10) @(posedge clk_i);
    if (pending_crcs.size() != 0) begin
      note_error("CRC never delivered", pending_crcs[0], '0);
    end
    if (error_count == 0) begin
      $display("PASS configurable_crc16_engine");
    end else begin
      $display("FAIL configurable_crc16_engine");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL configurable_crc16_engine");
    $finish;
  end

endmodule

@@ filelist.f @@
src/cfcrc_pkg.sv
src/cfcrc_cfg.sv
src/cfcrc_fold.sv
src/configurable_crc16_engine.sv
test/tb.sv
